// ===== src/wca_pkg.sv =====
// ----------------------------------------------------------------------------
// wca_pkg
// shared types, codes and small decode functions for the wheel cursor block
// ----------------------------------------------------------------------------
package wca_pkg;

    // configuration register indexes
    localparam logic [3:0] CFG_STEP_PERIOD = 4'd0;
    localparam logic [3:0] CFG_X_LIMIT     = 4'd1;
    localparam logic [3:0] CFG_Y_LIMIT     = 4'd2;
    localparam logic [3:0] CFG_WHEEL_SPEED = 4'd3;

    // register reset values
    localparam logic [15:0] RST_STEP_PERIOD = 16'd10;
    localparam logic [11:0] RST_X_LIMIT     = 12'd319;
    localparam logic [11:0] RST_Y_LIMIT     = 12'd239;
    localparam logic [6:0]  RST_WHEEL_SPEED = 7'd5;

    // wheel status byte that means touched
    localparam logic [7:0] WHEEL_TOUCHED = 8'hC0;

    // touch direction code for no touch or button held
    localparam logic [3:0] DIR_NONE = 4'd8;

    // first wheel position that wraps back to north
    localparam logic [6:0] WHEEL_WRAP = 7'd90;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } t_sign;

    // per-poll control shared by both axis units
    typedef struct packed {
        logic step;   // rate gate open on this poll
        logic run;    // some axis has nonzero speed
    } t_axis_ctrl;

    // quantize a wheel position into one of eight sectors, north first
    function automatic logic [2:0] wheel_dir(input logic [6:0] pos);
        logic [2:0] cnt;
        cnt = 3'd0;
        if (pos < WHEEL_WRAP) begin
            for (int k = 1; k < 8; k++) begin
                if (pos >= 7'(12 * k - 6)) cnt = cnt + 3'd1;
            end
        end
        return cnt;
    endfunction

    // x sign for each compass direction, clockwise from north
    function automatic t_sign dir_dx(input logic [2:0] dir);
        t_sign s;
        case (dir)
            3'd1, 3'd2, 3'd3: s = SGN_POS;
            3'd5, 3'd6, 3'd7: s = SGN_NEG;
            default:          s = SGN_ZERO;
        endcase
        return s;
    endfunction

    // y sign for each compass direction, screen y grows downward
    function automatic t_sign dir_dy(input logic [2:0] dir);
        t_sign s;
        case (dir)
            3'd0, 3'd1, 3'd7: s = SGN_NEG;
            3'd3, 3'd4, 3'd5: s = SGN_POS;
            default:          s = SGN_ZERO;
        endcase
        return s;
    endfunction

endpackage

// ===== src/wca_axis.sv =====
// ----------------------------------------------------------------------------
// wca_axis
// one axis of the movement step: hold timing, acceleration, move and clamp
// ----------------------------------------------------------------------------
module wca_axis #(
    parameter int COORD_BITS = 12,
    parameter int SPEED_BITS = 8
) (
    input  wca_pkg::t_axis_ctrl            i_ctrl,
    input  logic [31:0]                    i_now,
    input  logic [15:0]                    i_period,
    input  logic [11:0]                    i_limit,
    input  logic [COORD_BITS-1:0]          i_pos,
    input  logic signed [SPEED_BITS-1:0]   i_speed,
    input  logic [1:0]                     i_phase,
    input  logic [31:0]                    i_hold_start,
    output logic [COORD_BITS-1:0]          o_pos,
    output logic signed [SPEED_BITS-1:0]   o_speed,
    output logic [1:0]                     o_phase,
    output logic [31:0]                    o_hold_start
);
    import wca_pkg::*;

    localparam int LW   = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int SUMW = ((COORD_BITS > SPEED_BITS) ? COORD_BITS : SPEED_BITS) + 2;
    localparam logic [LW-1:0] COORD_MAX_L = LW'({COORD_BITS{1'b1}});
    localparam logic signed [SPEED_BITS:0] SMAX_W =
        (SPEED_BITS+1)'((1 << (SPEED_BITS - 1)) - 1);
    localparam logic signed [SPEED_BITS:0] ONE_W  = (SPEED_BITS+1)'(1);
    localparam logic signed [SPEED_BITS:0] FIVE_W = (SPEED_BITS+1)'(5);

    logic [1:0]                  phase1;
    logic [31:0]                 start1;
    logic [33:0]                 thr8;
    logic [33:0]                 thr12;
    logic                        past8;
    logic                        past12;
    logic                        spd_pos;
    logic signed [SPEED_BITS:0]  spd_w;
    logic signed [SPEED_BITS:0]  spd_a;
    logic signed [SPEED_BITS:0]  spd_s;
    logic [LW-1:0]               lim_l;
    logic [COORD_BITS-1:0]       lim_c;
    logic signed [SUMW-1:0]      p_sum;
    logic signed [SUMW-1:0]      lim_s;

    always_comb begin
        // a fresh press starts its hold timer on the first open step
        if (i_ctrl.step && (i_phase == 2'd1)) begin
            phase1 = 2'd2;
            start1 = i_now;
        end else begin
            phase1 = i_phase;
            start1 = i_hold_start;
        end

        // thresholds kept 34 bits wide so they never wrap
        thr8   = {2'b00, start1} + {15'd0, i_period, 3'b000};
        thr12  = thr8 + {16'd0, i_period, 2'b00};
        past8  = {2'b00, i_now} > thr8;
        past12 = {2'b00, i_now} > thr12;

        spd_pos = !i_speed[SPEED_BITS-1] && (i_speed != '0);
        spd_w   = {i_speed[SPEED_BITS-1], i_speed};

        if ((phase1 != 2'd0) && past12) begin
            spd_a = spd_pos ? (spd_w + ONE_W) : (spd_w - ONE_W);
        end else if ((phase1 != 2'd0) && past8) begin
            spd_a = spd_pos ? FIVE_W : -FIVE_W;
        end else begin
            spd_a = spd_w;
        end

        if (spd_a > SMAX_W)       spd_s = SMAX_W;
        else if (spd_a < -SMAX_W) spd_s = -SMAX_W;
        else                      spd_s = spd_a;

        // limit cut to the coordinate range
        lim_l = LW'(i_limit);
        if (lim_l > COORD_MAX_L) lim_l = COORD_MAX_L;
        lim_c = lim_l[COORD_BITS-1:0];

        p_sum = $signed({{(SUMW-COORD_BITS){1'b0}}, i_pos})
              + $signed({{(SUMW-SPEED_BITS-1){spd_s[SPEED_BITS]}}, spd_s});
        lim_s = $signed({{(SUMW-COORD_BITS){1'b0}}, lim_c});

        o_hold_start = start1;
        if (i_ctrl.step && i_ctrl.run) begin
            if (p_sum < 0) begin
                // clamp at zero; speed drops to minus one and the hold restarts
                o_pos   = '0;
                o_speed = '1;
                o_phase = 2'd1;
            end else if (p_sum > lim_s) begin
                // clamp at the limit; speed drops to one and the hold restarts
                o_pos   = lim_c;
                o_speed = SPEED_BITS'(1);
                o_phase = 2'd1;
            end else begin
                o_pos   = p_sum[COORD_BITS-1:0];
                o_speed = spd_s[SPEED_BITS-1:0];
                o_phase = phase1;
            end
        end else begin
            o_pos   = i_pos;
            o_speed = i_speed;
            o_phase = phase1;
        end
    end

endmodule

// ===== src/wheel_cursor_accelerator_top.sv =====
// ----------------------------------------------------------------------------
// wheel_cursor_accelerator_top
// touch-wheel cursor accelerator: rate-gated step, axis acceleration, clamp
// and wheel direction decode, one poll word in, one cursor word out
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | poll word, 48 bits
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | cursor word, 32 bits
//  cfg       | in        | i_cfg_valid / o_cfg_ready      | index 4 bits, data 16 bits
//
//  one poll word per cycle sustained while m_axis is not stalled; each word passes
//  the input register, then the step logic into the output register
//  the state registers update on the cycle a word leaves the input register
//  reset is synchronous, active low, and restores all but the data registers
//  a stall on m_axis holds both stages; s_axis keeps accepting while the
//  input register is empty or drains in the same cycle
//  config writes are always accepted and take effect on the next cycle
// ----------------------------------------------------------------------------
module wheel_cursor_accelerator_top #(
    parameter int COORD_BITS = 12,
    parameter int SPEED_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] now_ms, [39:32] wheel_status, [46:40] wheel_position,
    // [47] button_held
    input  logic [47:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] cursor_moved,
    // [28:25] touch_direction, [31:29] zero
    output logic [31:0] m_axis_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import wca_pkg::*;

    localparam int PW = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int WW = ((SPEED_BITS > 7) ? SPEED_BITS : 7) + 1;
    localparam logic [WW-1:0] SMAX_X = WW'((1 << (SPEED_BITS - 1)) - 1);

    // configuration registers
    logic [15:0] r_step_period;
    logic [11:0] r_x_limit;
    logic [11:0] r_y_limit;
    logic [6:0]  r_wheel_speed;

    // input stage
    logic        r_in_valid;
    logic [31:0] r_in_now;
    logic [7:0]  r_in_status;
    logic [6:0]  r_in_wpos;
    logic        r_in_held;

    // output stage
    logic        r_out_valid;
    logic [11:0] r_out_x;
    logic [11:0] r_out_y;
    logic        r_out_moved;
    logic [3:0]  r_out_dir;

    // block state
    logic [31:0]                   r_last_step, n_last_step;
    logic [31:0]                   r_x_start, n_x_start;
    logic [31:0]                   r_y_start, n_y_start;
    logic [1:0]                    r_x_phase, n_x_phase;
    logic [1:0]                    r_y_phase, n_y_phase;
    logic signed [SPEED_BITS-1:0]  r_x_speed, n_x_speed;
    logic signed [SPEED_BITS-1:0]  r_y_speed, n_y_speed;
    logic [COORD_BITS-1:0]         r_pos_x, n_pos_x;
    logic [COORD_BITS-1:0]         r_pos_y, n_pos_y;

    logic                          adv;
    t_axis_ctrl                    ctrl;
    logic [COORD_BITS-1:0]         ax_pos_x, ax_pos_y;
    logic signed [SPEED_BITS-1:0]  ax_spd_x, ax_spd_y;
    logic [1:0]                    ax_ph_x, ax_ph_y;
    logic [3:0]                    n_dir;
    logic [2:0]                    sector;
    logic [WW-1:0]                 ws_ext;
    logic signed [SPEED_BITS-1:0]  ws_pos;
    logic signed [SPEED_BITS-1:0]  ws_neg;
    logic [PW-1:0]                 px_ext, py_ext;
    t_sign                         sgn_x, sgn_y;

    // pipeline handshake: the input stage drains whenever the output stage
    // is empty or being taken
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_dir, r_out_moved, r_out_y, r_out_x};
    assign o_cfg_ready   = 1'b1;

    // rate gate, compared without wrap-around
    assign ctrl.step = {1'b0, r_in_now} >= ({1'b0, r_last_step} + {17'd0, r_step_period});
    assign ctrl.run  = (r_x_speed != '0) || (r_y_speed != '0);

    wca_axis #(
        .COORD_BITS (COORD_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_axis_x (
        .i_ctrl       (ctrl),
        .i_now        (r_in_now),
        .i_period     (r_step_period),
        .i_limit      (r_x_limit),
        .i_pos        (r_pos_x),
        .i_speed      (r_x_speed),
        .i_phase      (r_x_phase),
        .i_hold_start (r_x_start),
        .o_pos        (ax_pos_x),
        .o_speed      (ax_spd_x),
        .o_phase      (ax_ph_x),
        .o_hold_start (n_x_start)
    );

    wca_axis #(
        .COORD_BITS (COORD_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_axis_y (
        .i_ctrl       (ctrl),
        .i_now        (r_in_now),
        .i_period     (r_step_period),
        .i_limit      (r_y_limit),
        .i_pos        (r_pos_y),
        .i_speed      (r_y_speed),
        .i_phase      (r_y_phase),
        .i_hold_start (r_y_start),
        .o_pos        (ax_pos_y),
        .o_speed      (ax_spd_y),
        .o_phase      (ax_ph_y),
        .o_hold_start (n_y_start)
    );

    // wheel decode sets the speeds for the next poll; a held button keeps the axis results
    always_comb begin
        n_last_step = ctrl.step ? r_in_now : r_last_step;
        n_pos_x     = ax_pos_x;
        n_pos_y     = ax_pos_y;

        // wheel speed cut to the speed range
        ws_ext = WW'(r_wheel_speed);
        if (ws_ext > SMAX_X) ws_ext = SMAX_X;
        ws_pos = ws_ext[SPEED_BITS-1:0];
        ws_neg = -ws_pos;

        sector = wheel_dir(r_in_wpos);
        if (r_in_status == WHEEL_TOUCHED) begin
            sgn_x = dir_dx(sector);
            sgn_y = dir_dy(sector);
        end else begin
            sgn_x = SGN_ZERO;
            sgn_y = SGN_ZERO;
        end

        if (r_in_held) begin
            // button held freezes the wheel
            n_dir     = DIR_NONE;
            n_x_speed = ax_spd_x;
            n_y_speed = ax_spd_y;
            n_x_phase = ax_ph_x;
            n_y_phase = ax_ph_y;
        end else begin
            n_dir = (r_in_status == WHEEL_TOUCHED) ? {1'b0, sector} : DIR_NONE;
            case (sgn_x)
                SGN_POS: begin n_x_speed = ws_pos; n_x_phase = 2'd1; end
                SGN_NEG: begin n_x_speed = ws_neg; n_x_phase = 2'd1; end
                default: begin n_x_speed = '0;     n_x_phase = 2'd0; end
            endcase
            case (sgn_y)
                SGN_POS: begin n_y_speed = ws_pos; n_y_phase = 2'd1; end
                SGN_NEG: begin n_y_speed = ws_neg; n_y_phase = 2'd1; end
                default: begin n_y_speed = '0;     n_y_phase = 2'd0; end
            endcase
        end

        px_ext = PW'(ax_pos_x);
        py_ext = PW'(ax_pos_y);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= RST_STEP_PERIOD;
            r_x_limit     <= RST_X_LIMIT;
            r_y_limit     <= RST_Y_LIMIT;
            r_wheel_speed <= RST_WHEEL_SPEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP_PERIOD: r_step_period <= i_cfg_data;
                CFG_X_LIMIT:     r_x_limit     <= i_cfg_data[11:0];
                CFG_Y_LIMIT:     r_y_limit     <= i_cfg_data[11:0];
                CFG_WHEEL_SPEED: r_wheel_speed <= i_cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_now    <= s_axis_tdata[31:0];
            r_in_status <= s_axis_tdata[39:32];
            r_in_wpos   <= s_axis_tdata[46:40];
            r_in_held   <= s_axis_tdata[47];
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_step <= '0;
            r_x_start   <= '0;
            r_y_start   <= '0;
            r_x_phase   <= '0;
            r_y_phase   <= '0;
            r_x_speed   <= '0;
            r_y_speed   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_last_step <= n_last_step;
            r_x_start   <= n_x_start;
            r_y_start   <= n_y_start;
            r_x_phase   <= n_x_phase;
            r_y_phase   <= n_y_phase;
            r_x_speed   <= n_x_speed;
            r_y_speed   <= n_y_speed;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x     <= px_ext[11:0];
            r_out_y     <= py_ext[11:0];
            r_out_moved <= ctrl.step && ctrl.run;
            r_out_dir   <= n_dir;
        end
    end

    // hold phase only ever takes idle, just pressed or timing
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x_phase != 2'd3) && (r_y_phase != 2'd3))
        else $error("hold phase reached an unused code");

    // an open step records the poll time
    a_step_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && ctrl.step) |=> (r_last_step == $past(r_in_now)))
        else $error("step time not recorded");

    // a held button always reports no direction
    a_held_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_held) |=> (r_out_dir == DIR_NONE))
        else $error("direction reported while button held");

    // an untouched wheel without the button stops both axes
    a_release_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_in_held && (r_in_status != WHEEL_TOUCHED)) |=>
        ((r_x_speed == '0) && (r_y_speed == '0) &&
         (r_x_phase == 2'd0) && (r_y_phase == 2'd0)))
        else $error("axes still moving after wheel release");

endmodule
